### rtl/cfpa_pkg.sv
// ----------------------------------------------------------------------------
// cfpa_pkg
// Shared defaults and codes for the complex fixed-point arithmetic unit.
// ----------------------------------------------------------------------------
package cfpa_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int ACT_W          = 3;
    localparam int ORD_W          = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_MAG = 3'd4,
        ACT_CMP = 3'd5
    } action_t;

    typedef enum logic [ORD_W-1:0] {
        ORD_LESS    = 2'd0,
        ORD_EQUAL   = 2'd1,
        ORD_GREATER = 2'd2
    } order_t;

endpackage

### rtl/complex_fixed_point_alu.sv
// Throughput: one word per cycle unless the skid slot is full; every stage takes a new
//   word, as each stage retires one quotient bit and early stages one root bit.
// Reset: synchronous, active low; clears the valid bits of stages, skid and output.
// ----------------------------------------------------------------------------
// complex_fixed_point_alu
// Pipelined complex add, subtract, multiply, divide, magnitude and magnitude
// compare on signed fixed-point operands with saturating results.
// ----------------------------------------------------------------------------
module complex_fixed_point_alu #(
    parameter int DATA_WIDTH = cfpa_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cfpa_pkg::FRAC_BITS_DEF,
    localparam int IN_TW     = ((cfpa_pkg::ACT_W + 4*DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_TW    = ((2*DATA_WIDTH + cfpa_pkg::ORD_W + 2 + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // action, a_real, a_imag, b_real, b_imag (lowest bit up), zero padded
    input  logic [IN_TW-1:0]  s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // res_real, res_imag, order, divide_by_zero, saturated (lowest bit up), zero padded
    output logic [OUT_TW-1:0] m_tdata
);

    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int AW   = cfpa_pkg::ACT_W;
    localparam int SUMW = 2*W + 2;          // signed sums of two products
    localparam int MW   = 2*W + 1;          // magnitude of such a sum
    localparam int NW   = MW + F;           // dividend after the fraction shift
    localparam int ND   = NW;               // one quotient bit per stage
    localparam int SRW  = W + 3;            // square root partial remainder
    localparam int OW   = 2*W + cfpa_pkg::ORD_W + 2;

    localparam logic [MW-1:0] LIM = MW'(1) << (W-1);

    typedef struct packed {
        logic [MW-1:0] rem;
        logic [NW-1:0] num;
        logic [W:0]    q;
        logic          ovf;
    } div_t;

    typedef struct packed {
        logic [AW-1:0]             act;
        logic [cfpa_pkg::ORD_W-1:0] ord;
        logic                      dz;
        logic                      re_neg;
        logic                      im_neg;
        logic [MW-1:0]             re_mag;
        logic [MW-1:0]             im_mag;
        div_t                      re_div;
        div_t                      im_div;
        logic [2*W-1:0]            den;
        logic [SRW-1:0]            sq_rem;
        logic [W-1:0]              sq_root;
        logic [2*W-1:0]            sq_src;
    } work_t;

    typedef struct packed {
        logic [W-1:0] val;
        logic         sat;
    } clamp_t;

    // ------------------------------------------------------------------
    // Helpers: one restoring division bit, one square root bit, clamp.
    // ------------------------------------------------------------------
    function automatic div_t div_bit(div_t d, logic [2*W-1:0] den);
        div_t          r;
        logic [MW-1:0] trial;
        logic          bit_q;
        trial = {d.rem[MW-2:0], d.num[NW-1]};
        bit_q = (trial >= {1'b0, den});
        r.rem = bit_q ? (trial - {1'b0, den}) : trial;
        r.num = d.num << 1;
        r.q   = {d.q[W-1:0], bit_q};
        r.ovf = d.ovf | d.q[W];
        return r;
    endfunction

    function automatic work_t work_step(work_t w, logic do_sqrt);
        work_t          r;
        logic [SRW-1:0] cur;
        logic [SRW-1:0] trial;
        r        = w;
        r.re_div = div_bit(w.re_div, w.den);
        r.im_div = div_bit(w.im_div, w.den);
        cur      = {w.sq_rem[W:0], w.sq_src[2*W-1 -: 2]};
        trial    = {1'b0, w.sq_root, 2'b01};
        if (do_sqrt) begin
            if (cur >= trial) begin
                r.sq_rem  = cur - trial;
                r.sq_root = {w.sq_root[W-2:0], 1'b1};
            end else begin
                r.sq_rem  = cur;
                r.sq_root = {w.sq_root[W-2:0], 1'b0};
            end
            r.sq_src = w.sq_src << 2;
        end
        return r;
    endfunction

    function automatic clamp_t clamp_val(logic neg, logic [MW-1:0] mag, logic ovf);
        clamp_t        r;
        logic [MW-1:0] mx;
        mx = neg ? LIM : (LIM - MW'(1));
        if (ovf || (mag > mx)) begin
            r.sat = 1'b1;
            r.val = mx[W-1:0];
        end else begin
            r.sat = 1'b0;
            r.val = neg ? W'(MW'(0) - mag) : mag[W-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Flow control: the whole pipe advances unless the skid slot is full.
    // ------------------------------------------------------------------
    logic en;
    logic take;
    logic out_free;

    logic              skid_valid_reg;
    logic [OW-1:0]     skid_data_reg;
    logic              out_valid_reg;
    logic [OW-1:0]     out_data_reg;

    assign en       = ~skid_valid_reg;
    assign s_tready = en;
    assign out_free = ~out_valid_reg | m_tready;

    // ------------------------------------------------------------------
    // Stage 1: unpack the word and form all eight products.
    // ------------------------------------------------------------------
    logic signed [W-1:0] in_ar, in_ai, in_br, in_bi;
    assign in_ar = $signed(s_tdata[AW     +: W]);
    assign in_ai = $signed(s_tdata[AW+W   +: W]);
    assign in_br = $signed(s_tdata[AW+2*W +: W]);
    assign in_bi = $signed(s_tdata[AW+3*W +: W]);

    logic                  v1_reg;
    logic [AW-1:0]         act1_reg;
    logic signed [W-1:0]   ar1_reg, ai1_reg, br1_reg, bi1_reg;
    logic signed [2*W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [2*W-1:0] aa_r_reg, aa_i_reg, bb_r_reg, bb_i_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            act1_reg <= s_tdata[AW-1:0];
            ar1_reg  <= in_ar;
            ai1_reg  <= in_ai;
            br1_reg  <= in_br;
            bi1_reg  <= in_bi;
            p_rr_reg <= in_ar * in_br;
            p_ii_reg <= in_ai * in_bi;
            p_ri_reg <= in_ar * in_bi;
            p_ir_reg <= in_ai * in_br;
            aa_r_reg <= in_ar * in_ar;
            aa_i_reg <= in_ai * in_ai;
            bb_r_reg <= in_br * in_br;
            bb_i_reg <= in_bi * in_bi;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: pick the signed real and imaginary sums for the action and
    // form both squared magnitudes.
    // ------------------------------------------------------------------
    logic                   v2_reg;
    logic [AW-1:0]          act2_reg;
    logic signed [SUMW-1:0] re_s2_reg, im_s2_reg;
    logic [2*W-1:0]         sa2_reg, sb2_reg;
    logic signed [SUMW-1:0] re_s2_next, im_s2_next;

    always_comb begin
        re_s2_next = '0;
        im_s2_next = '0;
        case (act1_reg)
            cfpa_pkg::ACT_ADD: begin
                re_s2_next = SUMW'(ar1_reg) + SUMW'(br1_reg);
                im_s2_next = SUMW'(ai1_reg) + SUMW'(bi1_reg);
            end
            cfpa_pkg::ACT_SUB: begin
                re_s2_next = SUMW'(ar1_reg) - SUMW'(br1_reg);
                im_s2_next = SUMW'(ai1_reg) - SUMW'(bi1_reg);
            end
            cfpa_pkg::ACT_MUL: begin
                re_s2_next = SUMW'(p_rr_reg) - SUMW'(p_ii_reg);
                im_s2_next = SUMW'(p_ri_reg) + SUMW'(p_ir_reg);
            end
            cfpa_pkg::ACT_DIV: begin
                re_s2_next = SUMW'(p_rr_reg) + SUMW'(p_ii_reg);
                im_s2_next = SUMW'(p_ir_reg) - SUMW'(p_ri_reg);
            end
            default: begin
                re_s2_next = '0;
                im_s2_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act2_reg  <= act1_reg;
            re_s2_reg <= re_s2_next;
            im_s2_reg <= im_s2_next;
            sa2_reg   <= $unsigned(aa_r_reg) + $unsigned(aa_i_reg);
            sb2_reg   <= $unsigned(bb_r_reg) + $unsigned(bb_i_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: split into sign and magnitude, rescale products, compare
    // magnitudes and seed the divider and square root.
    // ------------------------------------------------------------------
    logic [SUMW-1:0] re_abs, im_abs;
    logic [MW-1:0]   re_mag3, im_mag3;
    work_t           prep_next;

    always_comb begin
        re_abs  = re_s2_reg[SUMW-1] ? (SUMW'(0) - $unsigned(re_s2_reg)) : $unsigned(re_s2_reg);
        im_abs  = im_s2_reg[SUMW-1] ? (SUMW'(0) - $unsigned(im_s2_reg)) : $unsigned(im_s2_reg);
        re_mag3 = re_abs[MW-1:0];
        im_mag3 = im_abs[MW-1:0];

        prep_next        = '0;
        prep_next.act    = act2_reg;
        prep_next.re_neg = re_s2_reg[SUMW-1];
        prep_next.im_neg = im_s2_reg[SUMW-1];
        // truncate toward zero: shift the magnitude, keep the sign
        prep_next.re_mag = (act2_reg == cfpa_pkg::ACT_MUL) ? (re_mag3 >> F) : re_mag3;
        prep_next.im_mag = (act2_reg == cfpa_pkg::ACT_MUL) ? (im_mag3 >> F) : im_mag3;
        prep_next.dz     = (act2_reg == cfpa_pkg::ACT_DIV) && (sb2_reg == '0);
        if (sa2_reg < sb2_reg) begin
            prep_next.ord = cfpa_pkg::ORD_LESS;
        end else if (sa2_reg == sb2_reg) begin
            prep_next.ord = cfpa_pkg::ORD_EQUAL;
        end else begin
            prep_next.ord = cfpa_pkg::ORD_GREATER;
        end
        prep_next.re_div.num = NW'(re_mag3) << F;
        prep_next.im_div.num = NW'(im_mag3) << F;
        prep_next.den        = sb2_reg;
        prep_next.sq_src     = sa2_reg;
    end

    // ------------------------------------------------------------------
    // Iterative stages: stage k holds the word after k division steps.
    // ------------------------------------------------------------------
    work_t d_reg  [0:ND];
    work_t d_next [1:ND];
    logic  dv_reg [0:ND];

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg[0] <= prep_next;
        end
    end

    for (genvar k = 1; k <= ND; k++) begin : g_step
        always_comb d_next[k] = work_step(d_reg[k-1], (k <= W));

        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg[k] <= d_next[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k] <= 1'b0;
            end else if (en) begin
                dv_reg[k] <= dv_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            dv_reg[0] <= 1'b0;
        end else if (en) begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            dv_reg[0] <= v2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Final select and clamp, packed in output order.
    // ------------------------------------------------------------------
    work_t         fin;
    clamp_t        c_re, c_im;
    logic [W-1:0]  fin_re, fin_im;
    logic          fin_sat;
    logic [OW-1:0] fin_word;

    always_comb begin
        fin     = d_reg[ND];
        c_re    = '0;
        c_im    = '0;
        case (fin.act)
            cfpa_pkg::ACT_ADD, cfpa_pkg::ACT_SUB, cfpa_pkg::ACT_MUL: begin
                c_re = clamp_val(fin.re_neg, fin.re_mag, 1'b0);
                c_im = clamp_val(fin.im_neg, fin.im_mag, 1'b0);
            end
            cfpa_pkg::ACT_DIV: begin
                if (!fin.dz) begin
                    c_re = clamp_val(fin.re_neg, MW'(fin.re_div.q), fin.re_div.ovf);
                    c_im = clamp_val(fin.im_neg, MW'(fin.im_div.q), fin.im_div.ovf);
                end
            end
            cfpa_pkg::ACT_MAG: begin
                c_re = clamp_val(1'b0, MW'(fin.sq_root), 1'b0);
            end
            default: begin
                c_re = '0;
                c_im = '0;
            end
        endcase
        fin_re   = c_re.val;
        fin_im   = c_im.val;
        fin_sat  = c_re.sat | c_im.sat;
        fin_word = {fin_sat, fin.dz, fin.ord, fin_im, fin_re};
    end

    assign take = en & dv_reg[ND];

    // ------------------------------------------------------------------
    // Output register with one skid slot: when the output is held and a
    // word leaves the pipe, park it and stop the pipe next cycle.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= take;
            end
        end else if (take) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : fin_word;
        end else if (take) begin
            skid_data_reg <= fin_word;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TW'(out_data_reg);

`ifndef SYNTHESIS
    // a zero divisor always yields a clean zero result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2*W+2]) |->
            (m_tdata[2*W-1:0] == '0) && !m_tdata[2*W+3])
        else $error("divide by zero with nonzero result");

    // order is one of the three defined codes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2*W+1:2*W] != 2'd3))
        else $error("undefined order code");

    // a parked word stays parked until the output frees up
    assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !out_free) |=> (skid_valid_reg && $stable(skid_data_reg)))
        else $error("skid slot lost or changed");

    // the pipe never takes a word while the skid slot is full
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |=> ($stable(v1_reg) && $stable(dv_reg[ND])))
        else $error("pipe advanced while stalled");
`endif

endmodule
